### rtl/core/magma_pkg.sv
// shared types, constants and the s-box substitution for the magma cipher
// used by magma_ctrl, magma_datapath and magma_block_cipher
package magma_pkg;

    localparam int HALF_W   = 32;
    localparam int BLOCK_W  = 64;
    localparam int KEY_WORDS = 8;
    localparam int KIDX_W   = 3;
    localparam int ROUND_W  = 5;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd31;

    // operation codes carried in tuser
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // s-box rows, row 0 serves the most significant nibble
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic                load;       // capture an input block
        logic                round_en;   // run one feistel round
        logic                last_round; // final round, no half swap
        logic [KIDX_W-1:0]   key_idx;    // round key select
        logic                out_load;   // move the finished block to the output
    } magma_cmd_t;

    // nibble-wise substitution of one half word
    function automatic logic [HALF_W-1:0] sbox_sub(input logic [HALF_W-1:0] val);
        logic [HALF_W-1:0] res;
        res = '0;
        for (int n = 0; n < 8; n++)
        begin
            res[HALF_W-4-4*n +: 4] = SBOX[n][val[HALF_W-4-4*n +: 4]];
        end
        return res;
    endfunction

endpackage

### rtl/core/magma_ctrl.sv
// controller state machine: sequences 32 rounds and the output handshake
// depends on magma_pkg
module magma_ctrl import magma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_op,
    output logic       out_valid,
    input  logic       out_ready,
    output magma_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               op_reg, op_next;
    logic               out_valid_reg, out_valid_next;
    logic               slot_free;
    logic [ROUND_W-1:0] sched_pos;
    logic [KIDX_W-1:0]  key_idx;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // key schedule: k0..k7 three times then k7..k0, reversed for decrypt
    always_comb
    begin
        sched_pos = (op_reg == OP_DECRYPT) ? ~round_reg : round_reg;
        if (sched_pos[4:3] == 2'b11)
            key_idx = ~sched_pos[KIDX_W-1:0];
        else
            key_idx = sched_pos[KIDX_W-1:0];
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.round_en   = 1'b0;
        cmd.last_round = (round_reg == LAST_ROUND);
        cmd.key_idx    = key_idx;
        cmd.out_load   = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = in_op;
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            op_reg        <= OP_ENCRYPT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/magma_datapath.sv
// datapath: key words, feistel halves, shared round unit, output register
// depends on magma_pkg
module magma_datapath import magma_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  magma_cmd_t         cmd,
    input  logic [BLOCK_W-1:0] in_block,
    input  logic               key_we,
    input  logic [KIDX_W-1:0]  key_widx,
    input  logic [HALF_W-1:0]  key_wdata,
    output logic [BLOCK_W-1:0] out_block
);

    logic [HALF_W-1:0]  key_reg [KEY_WORDS];
    logic [HALF_W-1:0]  left_reg, left_next;
    logic [HALF_W-1:0]  right_reg, right_next;
    logic [BLOCK_W-1:0] out_reg;
    logic [HALF_W-1:0]  sum, sub, mixed;

    // round function: add key, substitute, rotate left by 11, mix into left
    always_comb
    begin
        sum   = right_reg + key_reg[cmd.key_idx];
        sub   = sbox_sub(sum);
        mixed = left_reg ^ {sub[20:0], sub[31:21]};
    end

    // half update
    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (cmd.load)
        begin
            left_next  = in_block[BLOCK_W-1:HALF_W];
            right_next = in_block[HALF_W-1:0];
        end
        else if (cmd.round_en)
        begin
            if (cmd.last_round)
            begin
                left_next = mixed;
            end
            else
            begin
                left_next  = right_reg;
                right_next = mixed;
            end
        end
    end

    // key words, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (key_we)
        begin
            key_reg[key_widx] <= key_wdata;
        end
    end

    // block halves and output block
    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        if (cmd.out_load)
            out_reg <= {left_reg, right_reg};
    end

    assign out_block = out_reg;

endmodule

### rtl/core/magma_block_cipher.sv
// magma 64-bit block cipher with stream interfaces and a key write port
// depends on magma_pkg, magma_ctrl, magma_datapath
//
// usage:
//   - load the 256-bit key through cfg_*: cfg_index selects key word 0..7
//     (round key k0..k7, big-endian), cfg_data is the word; always ready
//   - send a request on s_axis_*: tdata is the 64-bit block (left half in
//     the upper 32 bits), tuser[0] selects encrypt (0) or decrypt (1)
//   - the result block leaves on m_axis_* with tdata the 64-bit block
//   - one feistel round per cycle through a single shared round unit:
//     the 32 rounds run in the run state, then the done state loads the
//     output register; the next request is taken only back in idle
//   - s_axis_tready is high only while no block is in flight
//   - a finished result waits in the output register while the next block
//     is already being accepted and worked on; if the receiver still stalls
//     when that block is done, the block holds until the register frees
//   - reset clears all key words to zero and drops all valid flags
//   - write keys only while the block is idle
module magma_block_cipher import magma_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BLOCK_W-1:0] s_axis_tdata,   // [63:0] data_block
    input  logic               s_axis_tuser,   // [0] operation
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [BLOCK_W-1:0] m_axis_tdata,   // [63:0] result_block
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [KIDX_W-1:0]  cfg_index,
    input  logic [HALF_W-1:0]  cfg_data
);

    magma_cmd_t cmd;

    // key writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing
    magma_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // round datapath and key storage
    magma_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_block  (s_axis_tdata),
        .key_we    (cfg_valid),
        .key_widx  (cfg_index),
        .key_wdata (cfg_data),
        .out_block (m_axis_tdata)
    );

endmodule
